FILE: src/quoted_printable_decoder_defines.svh
// Assertion macros for the quoted-printable decoder.
// Included by the top level; relies on i_clk and i_rst_n being in scope.
`ifndef QUOTED_PRINTABLE_DECODER_DEFINES_SVH
`define QUOTED_PRINTABLE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define QPD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define QPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/qpd_pkg.sv
// Shared types for the quoted-printable decoder.
// Command and status groups between controller and datapath; no dependencies.
package qpd_pkg;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // take the input transaction and decode it
        logic load_blank;   // move the oldest held blank into the output register
        logic load_tail;    // move the pending decoded byte into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic plan_blanks;  // the offered byte flushes held blanks
        logic plan_tail;    // the offered byte yields a decoded byte
        logic blank_last;   // one blank left to flush
        logic tail_vld;     // a decoded byte waits behind the blanks
        logic slot_free;    // output register can take a result this cycle
    } t_sts;

endpackage

FILE: src/quoted_printable_decoder.sv
// Quoted-printable decoder, one encoded byte per input transaction. After an
// input transaction that decodes to results, the controller drops o_ready and
// moves one result a cycle into the output register while that register is
// free; a new input transaction is taken only once all results of the last
// one, held blanks and then the decoded byte, are loaded. A downstream stall
// holds the loading. Set i_cfg_wdata high with i_cfg_we to select Q mode (underscore
// decodes to space); write it only while the block is idle.
`include "quoted_printable_decoder_defines.svh"

module quoted_printable_decoder #(
    parameter int BLANK_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_stream,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);
    import qpd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    qpd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    qpd_dpath #(
        .BLANK_DEPTH (BLANK_DEPTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

    `QPD_ASSERT_IMPL(a_no_load_on_accept, cmd.accept, !(cmd.load_blank || cmd.load_tail), "result loaded while accepting")
    `QPD_ASSERT_IMPL(a_load_needs_slot, cmd.load_blank || cmd.load_tail, sts.slot_free, "output register overwritten")
    `QPD_ASSERT_NEXT(a_load_shows_valid, cmd.load_blank || cmd.load_tail, o_valid, "loaded result not presented")
    `QPD_ASSERT_NEXT(a_tail_is_last, cmd.load_tail, o_last_of_run, "decoded byte not marked last of run")

endmodule

FILE: src/qpd_ctrl.sv
// Sequencer for the quoted-printable decoder.
// Uses qpd_pkg command/status types; drives the datapath of qpd_dpath.
module qpd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  qpd_pkg::t_sts i_sts,
    output qpd_pkg::t_cmd o_cmd
);
    import qpd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BLANKS,
        S_TAIL
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    if (i_sts.plan_blanks) begin
                        n_state = S_BLANKS;
                    end else if (i_sts.plan_tail) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_BLANKS: begin
                o_cmd.load_blank = i_sts.slot_free;
                if (i_sts.slot_free && i_sts.blank_last) begin
                    n_state = i_sts.tail_vld ? S_TAIL : S_IDLE;
                end
            end
            S_TAIL: begin
                o_cmd.load_tail = i_sts.slot_free;
                if (i_sts.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/qpd_dpath.sv
// Datapath of the quoted-printable decoder: decode state, blank shift line,
// pending byte and output register. Uses qpd_pkg; commanded by qpd_ctrl.
module qpd_dpath #(
    parameter int BLANK_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_stream,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [7:0]    o_out_byte,
    output logic          o_last_of_run,
    input  qpd_pkg::t_cmd i_cmd,
    output qpd_pkg::t_sts o_sts
);
    import qpd_pkg::*;

    localparam int CW = $clog2(BLANK_DEPTH + 1);
    localparam int IW = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;

    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_USCORE = 8'h5F;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_TAB   = 8'h09;

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_EQ,
        PH_EQ_HEX,
        PH_CR
    } t_phase;

    // {is_hex, value}
    function automatic logic [4:0] f_hex(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            res = {1'b1, c[3:0] + 4'd9};
        end
        return res;
    endfunction

    logic                   r_qmode;
    t_phase                 r_phase,     n_phase;
    logic [7:0]             r_first,     n_first;
    logic [BLANK_DEPTH-1:0] r_blank,     n_blank;   // 1 = tab, oldest at bit 0
    logic [CW-1:0]          r_count,     n_count;
    logic [CW-1:0]          r_emit,      n_emit;
    logic                   r_tail_vld,  n_tail_vld;
    logic [7:0]             r_tail_byte, n_tail_byte;
    logic                   r_out_vld;
    logic [7:0]             r_out_byte;
    logic                   r_out_last;

    logic       d_blanks;
    logic       d_tail;
    logic [7:0] d_tail_byte;
    logic [4:0] hx1;
    logic [4:0] hx2;
    logic [7:0] esc_val;
    logic       is_blank;
    logic       is_tab;
    logic       slot_free;

    assign hx1      = f_hex(r_first);
    assign hx2      = f_hex(i_in_byte);
    assign esc_val  = !hx1[4] ? 8'd0 : (hx2[4] ? {hx1[3:0], hx2[3:0]} : {4'd0, hx1[3:0]});
    assign is_tab   = (i_in_byte == C_TAB);
    assign is_blank = is_tab || (i_in_byte == C_SPACE);
    assign slot_free = !r_out_vld || i_ready;

    always_comb begin
        n_phase     = r_phase;
        n_first     = r_first;
        n_blank     = r_blank;
        n_count     = r_count;
        n_emit      = r_emit;
        n_tail_vld  = r_tail_vld;
        n_tail_byte = r_tail_byte;
        d_blanks    = 1'b0;
        d_tail      = 1'b0;
        d_tail_byte = i_in_byte;

        // Decode of the offered byte; committed only on accept
        case (r_phase)
            PH_EQ: begin
                if (i_in_byte == C_LF) begin
                    n_phase = PH_NORMAL;
                end else begin
                    n_first = i_in_byte;
                    n_phase = PH_EQ_HEX;
                end
            end
            PH_EQ_HEX: begin
                d_tail      = (r_first != C_CR);
                d_tail_byte = esc_val;
                n_phase     = PH_NORMAL;
            end
            PH_CR: begin
                d_tail      = 1'b1;
                d_tail_byte = C_LF;
                n_phase     = PH_NORMAL;
            end
            default: begin
                if (is_blank) begin
                    if (r_count == CW'(BLANK_DEPTH)) begin
                        // Store full: evict the oldest blank, append the new one
                        d_tail      = 1'b1;
                        d_tail_byte = r_blank[0] ? C_TAB : C_SPACE;
                        n_blank     = r_blank >> 1;
                        n_blank[BLANK_DEPTH-1] = is_tab;
                    end else begin
                        n_blank[r_count[IW-1:0]] = is_tab;
                        n_count = r_count + CW'(1);
                    end
                end else begin
                    n_count = '0;
                    if (i_in_byte != C_CR && i_in_byte != C_LF) begin
                        d_blanks = (r_count != '0);
                        n_emit   = r_count;
                    end
                    if (i_in_byte == C_EQ) begin
                        n_phase = PH_EQ;
                    end else if (i_in_byte == C_CR) begin
                        n_phase = PH_CR;
                    end else begin
                        d_tail = 1'b1;
                        if (r_qmode && i_in_byte == C_USCORE) begin
                            d_tail_byte = C_SPACE;
                        end
                    end
                end
            end
        endcase

        if (i_end_of_stream) begin
            n_phase = PH_NORMAL;
            n_first = 8'd0;
            n_count = '0;
        end
        n_tail_vld  = d_tail;
        n_tail_byte = d_tail_byte;

        if (!i_cmd.accept) begin
            // Hold decode state; advance emission instead
            n_phase     = r_phase;
            n_first     = r_first;
            n_blank     = r_blank;
            n_count     = r_count;
            n_emit      = r_emit;
            n_tail_vld  = r_tail_vld;
            n_tail_byte = r_tail_byte;
            if (i_cmd.load_blank) begin
                n_blank = r_blank >> 1;
                n_emit  = r_emit - CW'(1);
            end
            if (i_cmd.load_tail) begin
                n_tail_vld = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qmode    <= 1'b0;
            r_phase    <= PH_NORMAL;
            r_first    <= 8'd0;
            r_count    <= '0;
            r_emit     <= '0;
            r_tail_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_qmode <= i_cfg_wdata;
            end
            r_phase    <= n_phase;
            r_first    <= n_first;
            r_count    <= n_count;
            r_emit     <= n_emit;
            r_tail_vld <= n_tail_vld;
            if (i_cmd.load_blank || i_cmd.load_tail) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blank     <= n_blank;
        r_tail_byte <= n_tail_byte;
        if (i_cmd.load_blank) begin
            r_out_byte <= r_blank[0] ? C_TAB : C_SPACE;
            r_out_last <= (r_emit == CW'(1)) && !r_tail_vld;
        end else if (i_cmd.load_tail) begin
            r_out_byte <= r_tail_byte;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

    assign o_sts.plan_blanks = d_blanks;
    assign o_sts.plan_tail   = d_tail;
    assign o_sts.blank_last  = (r_emit == CW'(1));
    assign o_sts.tail_vld    = r_tail_vld;
    assign o_sts.slot_free   = slot_free;

endmodule
